// File: rtl/core/voxrt_pkg.sv
// shared types and constants for the 3d voxel line unit
// no dependencies; imported by every module under rtl/core
package voxrt_pkg;

  localparam int MaxSteps = 64;
  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int MaxdW    = $clog2(MaxSteps + 1);
  localparam int ErrW     = MaxdW + 2;
  localparam int NumAxes  = 3;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [MaxdW-1:0]  maxd_t;

  // one classified ray waiting for the stepper
  typedef struct packed {
    logic [NumAxes-1:0][CoordW-1:0] origin;
    logic [NumAxes-1:0][MaxdW-1:0]  dlt;
    logic [NumAxes-1:0]             neg;
    maxd_t                          maxd;
    logic                           too_long;
  } ray_t;

  // handshake between queue and stepper
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

// File: rtl/core/voxrt_front.sv
// front end: captures a ray, forms axis distances and classifies it
// depends on voxrt_pkg; feeds voxrt_queue
module voxrt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  voxrt_pkg::coord_t    in_start_x,
  input  voxrt_pkg::coord_t    in_start_y,
  input  voxrt_pkg::coord_t    in_start_z,
  input  voxrt_pkg::coord_t    in_stop_x,
  input  voxrt_pkg::coord_t    in_stop_y,
  input  voxrt_pkg::coord_t    in_stop_z,
  input  voxrt_pkg::q_status_t q_stat,
  output logic                 push,
  output voxrt_pkg::ray_t      push_ray
);
  import voxrt_pkg::*;

  logic                          a_valid_r, a_valid_nxt;
  logic [NumAxes-1:0][CoordW-1:0] a_start_r;
  logic [NumAxes-1:0][DiffW-1:0]  a_diff_r;
  logic [NumAxes-1:0][DiffW-1:0]  diff_in;
  logic [NumAxes-1:0][DiffW-1:0]  mag;
  logic [DiffW-1:0]              max_xy, max_all;
  logic                          empty_ray, a_adv, accept;

  always_comb begin
    diff_in[0] = DiffW'($signed(in_stop_x)) - DiffW'($signed(in_start_x));
    diff_in[1] = DiffW'($signed(in_stop_y)) - DiffW'($signed(in_start_y));
    diff_in[2] = DiffW'($signed(in_stop_z)) - DiffW'($signed(in_start_z));
  end

  always_comb begin
    for (int j = 0; j < NumAxes; j++) begin
      mag[j] = a_diff_r[j][DiffW-1] ? (DiffW'(0) - a_diff_r[j]) : a_diff_r[j];
    end
    max_xy  = (mag[1] > mag[0]) ? mag[1] : mag[0];
    max_all = (mag[2] > max_xy) ? mag[2] : max_xy;
  end

  assign empty_ray = (max_all == '0);
  // a ray with no distance leaves without a queue slot
  assign a_adv     = empty_ray || !q_stat.full;
  assign busy      = a_valid_r && !a_adv;
  assign accept    = start && !busy;
  assign push      = a_valid_r && !empty_ray && !q_stat.full;

  always_comb begin
    push_ray.origin   = a_start_r;
    push_ray.too_long = (max_all > DiffW'(MaxSteps));
    push_ray.maxd     = max_all[MaxdW-1:0];
    for (int j = 0; j < NumAxes; j++) begin
      push_ray.dlt[j] = mag[j][MaxdW-1:0];
      push_ray.neg[j] = a_diff_r[j][DiffW-1];
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (a_valid_r && a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_start_r[0] <= in_start_x;
      a_start_r[1] <= in_start_y;
      a_start_r[2] <= in_start_z;
      a_diff_r     <= diff_in;
    end
  end

endmodule

// File: rtl/core/voxrt_queue.sv
// two-entry ray queue between front end and stepper
// depends on voxrt_pkg
module voxrt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  voxrt_pkg::ray_t      push_ray,
  input  logic                 pop,
  output voxrt_pkg::ray_t      head_ray,
  output voxrt_pkg::q_status_t q_stat
);
  import voxrt_pkg::*;

  ray_t             slot_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign head_ray         = slot_r[rd_ptr_r];
  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.full      = (cnt_r == QCntW'(QDepth));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ray;
    end
  end

endmodule

// File: rtl/core/voxrt_back.sv
// stepper: walks one ray per load, one voxel beat per cycle
// depends on voxrt_pkg; fed by voxrt_queue
module voxrt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  voxrt_pkg::ray_t      head_ray,
  input  voxrt_pkg::q_status_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  output voxrt_pkg::coord_t    out_voxel_x,
  output voxrt_pkg::coord_t    out_voxel_y,
  output voxrt_pkg::coord_t    out_voxel_z,
  output logic                 out_final_voxel,
  output logic                 out_too_long
);
  import voxrt_pkg::*;

  logic                           active_r, active_nxt;
  logic [NumAxes-1:0][CoordW-1:0] cur_r, cur_nxt;
  logic [NumAxes-1:0][ErrW-1:0]   err_r, err_nxt;
  logic [NumAxes-1:0][MaxdW-1:0]  dlt_r;
  logic [NumAxes-1:0]             neg_r;
  maxd_t                          maxd_r, idx_r, idx_nxt;
  logic                           tl_r;
  logic                           last;
  logic signed [ErrW-1:0]         sum;
  logic signed [ErrW:0]           twice, lim;

  assign last = tl_r || (idx_r == maxd_r - MaxdW'(1));
  assign pop  = q_stat.not_empty && (!active_r || last);

  assign out_valid       = active_r;
  assign out_voxel_x     = cur_r[0];
  assign out_voxel_y     = cur_r[1];
  assign out_voxel_z     = cur_r[2];
  assign out_final_voxel = last;
  assign out_too_long    = tl_r;

  always_comb begin
    sum     = '0;
    twice   = '0;
    lim     = $signed({3'b000, maxd_r});
    cur_nxt = cur_r;
    err_nxt = err_r;
    for (int j = 0; j < NumAxes; j++) begin
      sum   = $signed(err_r[j]) + $signed({2'b00, dlt_r[j]});
      twice = $signed({sum, 1'b0});
      err_nxt[j] = sum;
      // axis moves once twice its error reaches the major distance
      if (twice >= lim) begin
        cur_nxt[j] = neg_r[j] ? cur_r[j] - CoordW'(1) : cur_r[j] + CoordW'(1);
        err_nxt[j] = sum - $signed({2'b00, maxd_r});
      end
    end
    idx_nxt    = idx_r + MaxdW'(1);
    active_nxt = active_r && !last;
    if (pop) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head_ray.origin;
      err_r  <= '0;
      dlt_r  <= head_ray.dlt;
      neg_r  <= head_ray.neg;
      maxd_r <= head_ray.maxd;
      tl_r   <= head_ray.too_long;
      idx_r  <= '0;
    end else if (active_r) begin
      cur_r <= cur_nxt;
      err_r <= err_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/core/voxel_ray_traversal_3d_unit.sv
// 3d voxel line generator. a ray command is taken on a clock edge with start
// high and busy low; in_start_* is the origin voxel, in_stop_* the end voxel.
// each voxel of the line leaves as one beat on out_voxel_*, marked by
// out_valid for exactly one cycle; out_final_voxel flags the last beat of a
// ray. a ray whose major axis distance exceeds 64 gives a single beat with
// the origin, out_final_voxel and out_too_long set. a ray whose start equals
// its stop gives no beat at all, and the stop voxel itself is never emitted.
// path: with the stepper idle, a ray passes the front-end capture register and
// a queue slot before its first beat shows on out_voxel_*.
// throughput: the stepper puts out one beat per cycle, so a ray occupies it
// for its major distance in beats (1 to 64), one beat if too long; with
// rays waiting, the next ray's first beat follows the previous last beat
// directly. the front end and a two-entry queue take commands one per cycle
// until the queue fills, then busy holds further commands off.
// the receiver cannot stall: every beat must be taken when shown.
// reset (rst_n low, synchronous) empties the queue and stops any ray in flight.
// depends on voxrt_pkg, voxrt_front, voxrt_queue, voxrt_back
module voxel_ray_traversal_3d_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  voxrt_pkg::coord_t in_start_x,
  input  voxrt_pkg::coord_t in_start_y,
  input  voxrt_pkg::coord_t in_start_z,
  input  voxrt_pkg::coord_t in_stop_x,
  input  voxrt_pkg::coord_t in_stop_y,
  input  voxrt_pkg::coord_t in_stop_z,
  output logic              out_valid,
  output voxrt_pkg::coord_t out_voxel_x,
  output voxrt_pkg::coord_t out_voxel_y,
  output voxrt_pkg::coord_t out_voxel_z,
  output logic              out_final_voxel,
  output logic              out_too_long
);
  import voxrt_pkg::*;

  logic      push, pop;
  ray_t      push_ray, head_ray;
  q_status_t q_stat;

  voxrt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_start_z (in_start_z),
    .in_stop_x  (in_stop_x),
    .in_stop_y  (in_stop_y),
    .in_stop_z  (in_stop_z),
    .q_stat     (q_stat),
    .push       (push),
    .push_ray   (push_ray)
  );

  voxrt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ray (push_ray),
    .pop      (pop),
    .head_ray (head_ray),
    .q_stat   (q_stat)
  );

  voxrt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_ray        (head_ray),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_voxel_x     (out_voxel_x),
    .out_voxel_y     (out_voxel_y),
    .out_voxel_z     (out_voxel_z),
    .out_final_voxel (out_final_voxel),
    .out_too_long    (out_too_long)
  );

endmodule

// File: dv/testbench.sv
// testbench for voxel_ray_traversal_3d_unit: directed and random rays with a line predictor
// every voxel beat is checked in order against the predicted line; uses voxrt_pkg types
`timescale 1ns / 100ps

module testbench;
  import voxrt_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   fin;
    logic   tl;
  } voxel_beat_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_start_x, in_start_y, in_start_z;
  coord_t in_stop_x, in_stop_y, in_stop_z;
  logic   out_valid;
  coord_t out_voxel_x, out_voxel_y, out_voxel_z;
  logic   out_final_voxel;
  logic   out_too_long;

  voxel_beat_t expected_voxels[$];
  int          bad_beats = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;

  voxel_ray_traversal_3d_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_start_z     (in_start_z),
    .in_stop_x      (in_stop_x),
    .in_stop_y      (in_stop_y),
    .in_stop_z      (in_stop_z),
    .out_valid      (out_valid),
    .out_voxel_x    (out_voxel_x),
    .out_voxel_y    (out_voxel_y),
    .out_voxel_z    (out_voxel_z),
    .out_final_voxel(out_final_voxel),
    .out_too_long   (out_too_long)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walks the line from origin toward target and queues every voxel beat
  task automatic trace_line(input coord_t org[3], input coord_t dst[3]);
    int cur[3];
    int dlt[3];
    int dir[3];
    int err[3];
    int major;
    voxel_beat_t b;
    major = 0;
    for (int a = 0; a < 3; a++) begin
      cur[a] = $signed(org[a]);
      dlt[a] = int'($signed(dst[a])) - cur[a];
      dir[a] = (dlt[a] < 0) ? -1 : 1;
      if (dlt[a] < 0) dlt[a] = -dlt[a];
      err[a] = 0;
      if (dlt[a] > major) major = dlt[a];
    end
    if (major == 0) return;
    b.x = coord_t'(cur[0]);
    b.y = coord_t'(cur[1]);
    b.z = coord_t'(cur[2]);
    if (major > MaxSteps) begin
      b.fin = 1'b1;
      b.tl  = 1'b1;
      expected_voxels.insert(expected_voxels.size(), b);
      return;
    end
    b.fin = (major == 1);
    b.tl  = 1'b0;
    expected_voxels.insert(expected_voxels.size(), b);
    for (int i = 0; i < major - 1; i++) begin
      for (int a = 0; a < 3; a++) begin
        err[a] += dlt[a];
        if (err[a] * 2 >= major) begin
          cur[a] += dir[a];
          err[a] -= major;
        end
      end
      b.x   = coord_t'(cur[0]);
      b.y   = coord_t'(cur[1]);
      b.z   = coord_t'(cur[2]);
      b.fin = (i == major - 2);
      expected_voxels.insert(expected_voxels.size(), b);
    end
  endtask

  // start stays high on return so back-to-back rays need no second assignment
  task automatic send_ray(input coord_t sx, input coord_t sy, input coord_t sz,
                          input coord_t tx, input coord_t ty, input coord_t tz);
    coord_t org[3];
    coord_t dst[3];
    org = '{sx, sy, sz};
    dst = '{tx, ty, tz};
    if (!steady && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_start_x <= sx;
    in_start_y <= sy;
    in_start_z <= sz;
    in_stop_x  <= tx;
    in_stop_y  <= ty;
    in_stop_z  <= tz;
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    trace_line(org, dst);
  endtask

  task automatic test_degenerate();
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_ray(-16'sd32768, 16'sd32767, -16'sd1, -16'sd32768, 16'sd32767, -16'sd1);
    send_ray(16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5, 16'sd5);
    send_ray(16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1, -16'sd1);
    send_ray(16'sd100, -16'sd7, 16'sd3, 16'sd100, -16'sd7, 16'sd2);
  endtask

  task automatic test_extremes();
    send_ray(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    send_ray(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768);
    send_ray(16'sd32767, 16'sd0, -16'sd32768, 16'sd32764, 16'sd2, -16'sd32704);
    send_ray(-16'sd32768, 16'sd32767, 16'sd0, -16'sd32704, 16'sd32703, 16'sd0);
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd65, 16'sd0, 16'sd0);
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd64, 16'sd0);
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd63);
    send_ray(16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, -16'sd56);
  endtask

  task automatic test_axes();
    steady = 1'b1;
    send_ray(16'sd10, 16'sd20, 16'sd30, 16'sd30, -16'sd5, 16'sd37);
    send_ray(-16'sd3, 16'sd4, 16'sd1, 16'sd2, -16'sd29, -16'sd8);
    send_ray(16'sd200, -16'sd200, 16'sd0, 16'sd190, -16'sd195, 16'sd40);
    send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7, -16'sd7);
    send_ray(16'sd1, 16'sd2, 16'sd3, -16'sd10, 16'sd13, 16'sd4);
    steady = 1'b0;
  endtask

  // mostly short lines with random content, plus zero, near-limit and far rays
  task automatic test_random(input int count);
    int kind;
    int lim;
    coord_t s[3];
    coord_t t[3];
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 3 + 40);
      kind = $urandom_range(99);
      for (int a = 0; a < 3; a++) s[a] = coord_t'($urandom);
      if (kind < 8) begin
        t = s;
      end else if (kind < 16) begin
        for (int a = 0; a < 3; a++) t[a] = coord_t'($urandom);
      end else if (kind < 26) begin
        for (int a = 0; a < 3; a++) t[a] = s[a] + coord_t'(int'($urandom_range(140)) - 70);
      end else begin
        lim = ($urandom_range(3) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
        for (int a = 0; a < 3; a++) begin
          t[a] = s[a] + coord_t'(int'($urandom_range(2 * lim)) - lim);
        end
      end
      send_ray(s[0], s[1], s[2], t[0], t[1], t[2]);
    end
    steady = 1'b0;
  endtask

  // beat checker and stall watchdog
  always @(posedge clk) begin
    voxel_beat_t got;
    voxel_beat_t want;
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      got = '{out_voxel_x, out_voxel_y, out_voxel_z, out_final_voxel, out_too_long};
      if (out_valid !== 1'b1 || expected_voxels.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) begin
          $display("unexpected beat: valid=%b x=%h y=%h z=%h final=%b too_long=%b",
                   out_valid, got.x, got.y, got.z, got.fin, got.tl);
        end
      end else begin
        want = expected_voxels.pop_front();
        if (got !== want) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("beat mismatch: exp x=%h y=%h z=%h final=%b too_long=%b",
                     want.x, want.y, want.z, want.fin, want.tl);
            $display("               got x=%h y=%h z=%h final=%b too_long=%b",
                     got.x, got.y, got.z, got.fin, got.tl);
          end
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_start_z = '0;
    in_stop_x  = '0;
    in_stop_y  = '0;
    in_stop_z  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degenerate();
    test_extremes();
    test_axes();
    test_random(162);
    start <= 1'b0;
    while (expected_voxels.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (DrainCycles) @(posedge clk);
    if (bad_beats == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/voxrt_pkg.sv
rtl/core/voxrt_front.sv
rtl/core/voxrt_queue.sv
rtl/core/voxrt_back.sv
rtl/core/voxel_ray_traversal_3d_unit.sv
dv/testbench.sv
